### rtl/cdtx_pkg.sv
package cdtx_pkg;

    localparam int unsigned C_MAX_PACKS   = 2048;
    localparam logic [11:0] C_MAX_PACKS_W = 12'(C_MAX_PACKS);

    localparam logic [15:0] C_CRC_POLY = 16'h1021;
    localparam logic [15:0] C_CRC_INV  = 16'hFFFF;

    localparam int unsigned C_BUF_DEPTH = 5;
    localparam logic [2:0]  C_CNT_HDR   = 3'd5;
    localparam logic [2:0]  C_CNT_CRC   = 3'd3;
    localparam logic [2:0]  C_CNT_ONE   = 3'd1;

    localparam logic [3:0]  C_LAST_BYTE = 4'd15;

    localparam logic        C_REG_PACK_COUNT = 1'b0;

    typedef struct packed {
        logic [C_BUF_DEPTH-1:0][7:0] bytes;
        logic [2:0]                  cnt;
        logic                        fin;
    } t_frame;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = (c << 1) ^ C_CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/cdtx_out_buf.sv
module cdtx_out_buf
    import cdtx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_frame     i_frame,
    output logic       o_ready,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

    logic [C_BUF_DEPTH-1:0][7:0] r_buf, n_buf;
    logic [2:0]                  r_cnt, n_cnt;
    logic                        r_fin, n_fin;
    logic                        w_take;

    assign o_tvalid = (r_cnt != 3'd0);
    assign w_take   = o_tvalid & i_tready;
    assign o_ready  = (r_cnt == 3'd0) || ((r_cnt == C_CNT_ONE) && i_tready);
    assign o_tdata  = r_buf[0];
    assign o_tlast  = r_fin && (r_cnt == C_CNT_ONE);

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        n_fin = r_fin;
        if (i_load) begin
            n_buf = i_frame.bytes;
            n_cnt = i_frame.cnt;
            n_fin = i_frame.fin;
        end else if (w_take) begin
            n_buf = {8'h00, r_buf[C_BUF_DEPTH-1:1]};
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_fin <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_fin <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> ((r_cnt == 3'd0) || ((r_cnt == C_CNT_ONE) && w_take)))
        else $error("load over pending bytes");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(C_BUF_DEPTH))
        else $error("byte count out of range");

    a_keep_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_load && (r_cnt > C_CNT_ONE)) |=> o_tvalid)
        else $error("bytes dropped");

endmodule

### rtl/cd_text_pack_crc_framer.sv
// CD-TEXT pack framer. Takes 16 payload bytes per pack on s_axis and sends the framed
// stream on m_axis, one byte per cycle while m_axis_tready is high: a four-byte header
// (18*pack_count+2 big-endian, then two zeros) before the first byte of a stream, each
// payload byte, and after every 16th byte the inverted CRC-16 (poly 0x1021, init 0) high
// byte first. tlast marks the last CRC byte of the final pack, after which the next byte
// starts a new stream. An accepted byte yields 1, 3 or 5 output bytes held in a five-byte
// output buffer; the next byte is taken in the cycle the buffer's final byte leaves, so
// the input waits until earlier output bytes are sent: 5 for a stream's first byte, 3 for
// a pack's 16th, 1 otherwise (18 output bytes per pack). pack_count is clamped to
// 1..2048; write it only while the block is idle.
module cd_text_pack_crc_framer
    import cdtx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pack_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tlast,   // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [11:0] r_pack_count;
    logic [15:0] r_crc, n_crc;
    logic [3:0]  r_byte_in_pack, n_byte_in_pack;
    logic [11:0] r_packs_done, n_packs_done;
    logic        r_header_sent, n_header_sent;

    logic [11:0] w_eff;
    logic [15:0] w_len;
    logic [15:0] w_crc_nxt;
    logic [15:0] w_crc_out;
    logic [11:0] w_done;
    logic        w_pack_end;
    logic        w_fin;
    logic        w_acc;
    logic        w_buf_ready;
    t_frame      w_frame;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == C_REG_PACK_COUNT) ? {20'h00000, r_pack_count} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pack_count <= 12'd1;
        end else if (psel && penable && pwrite && (paddr[2] == C_REG_PACK_COUNT)) begin
            r_pack_count <= pwdata[11:0];
        end
    end

    // framing
    assign s_axis_tready = w_buf_ready;
    assign w_acc         = s_axis_tvalid & w_buf_ready;

    always_comb begin
        if (r_pack_count == 12'd0) begin
            w_eff = 12'd1;
        end else if (r_pack_count > C_MAX_PACKS_W) begin
            w_eff = C_MAX_PACKS_W;
        end else begin
            w_eff = r_pack_count;
        end
    end

    assign w_len      = ({4'h0, w_eff} << 4) + ({4'h0, w_eff} << 1) + 16'd2;
    assign w_crc_nxt  = crc_feed(r_crc, s_axis_tdata);
    assign w_crc_out  = w_crc_nxt ^ C_CRC_INV;
    assign w_done     = r_packs_done + 12'd1;
    assign w_pack_end = (r_byte_in_pack == C_LAST_BYTE);
    assign w_fin      = w_pack_end && (w_done >= w_eff);

    always_comb begin
        w_frame.bytes = '0;
        w_frame.fin   = w_fin;
        if (!r_header_sent) begin
            w_frame.bytes[0] = w_len[15:8];
            w_frame.bytes[1] = w_len[7:0];
            w_frame.bytes[4] = s_axis_tdata;
            w_frame.cnt      = C_CNT_HDR;
        end else if (w_pack_end) begin
            w_frame.bytes[0] = s_axis_tdata;
            w_frame.bytes[1] = w_crc_out[15:8];
            w_frame.bytes[2] = w_crc_out[7:0];
            w_frame.cnt      = C_CNT_CRC;
        end else begin
            w_frame.bytes[0] = s_axis_tdata;
            w_frame.cnt      = C_CNT_ONE;
        end
    end

    always_comb begin
        n_crc          = r_crc;
        n_byte_in_pack = r_byte_in_pack;
        n_packs_done   = r_packs_done;
        n_header_sent  = r_header_sent;
        if (w_acc) begin
            n_byte_in_pack = r_byte_in_pack + 4'd1;
            n_header_sent  = 1'b1;
            if (w_pack_end) begin
                n_crc = 16'h0000;
                if (w_fin) begin
                    n_packs_done  = 12'd0;
                    n_header_sent = 1'b0;
                end else begin
                    n_packs_done = w_done;
                end
            end else begin
                n_crc = w_crc_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc          <= 16'h0000;
            r_byte_in_pack <= 4'd0;
            r_packs_done   <= 12'd0;
            r_header_sent  <= 1'b0;
        end else begin
            r_crc          <= n_crc;
            r_byte_in_pack <= n_byte_in_pack;
            r_packs_done   <= n_packs_done;
            r_header_sent  <= n_header_sent;
        end
    end

    cdtx_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_acc),
        .i_frame  (w_frame),
        .o_ready  (w_buf_ready),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    a_crc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_pack_end) |=> (r_crc == 16'h0000))
        else $error("crc not cleared at pack end");

    a_header_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !r_header_sent) |=> r_header_sent)
        else $error("header not marked sent");

    a_stream_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_fin) |=> (!r_header_sent && (r_packs_done == 12'd0)))
        else $error("stream did not re-arm");

endmodule

### tb/sv/cd_text_pack_crc_framer_test.sv
`timescale 1ns / 1ps

module cd_text_pack_crc_framer_test;
    import cdtx_pkg::*;

    localparam logic [2:0] ADDR_PACK_COUNT = {C_REG_PACK_COUNT, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;
    localparam int         BYTES_PER_PACK  = 16;
    localparam int         RANDOM_ITEMS    = 288;
    localparam int         RX_HOLD_CYCLES  = 300;
    localparam int         TAIL_CYCLES     = 12;
    localparam int         MAX_PRINTED     = 40;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_framed_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // pack_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // out_byte
    logic        m_axis_tlast;        // last
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [11:0]  shadow_pack_count = 12'd1;
    logic [15:0]  crc_acc = '0;
    logic [3:0]   pack_pos = '0;
    logic [11:0]  packs_out = '0;
    logic         hdr_sent = 1'b0;
    t_framed_byte framed_q[$];

    int err_count = 0;
    int tx_burst_left = 0;
    bit tx_free = 1'b0;
    bit rx_free = 1'b0;
    int hold_req = 0;

    cd_text_pack_crc_framer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        repeat (8) c = c[15] ? ((c << 1) ^ C_CRC_POLY) : (c << 1);
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
        err_count++;
    endtask

    task automatic predict_frame(input logic [7:0] b);
        logic [11:0] limit;
        logic [15:0] hdr_len;
        logic [15:0] crc_out;
        logic [11:0] done;
        logic        fin;
        limit = shadow_pack_count;
        if (limit == 12'd0) limit = 12'd1;
        if (limit > C_MAX_PACKS_W) limit = C_MAX_PACKS_W;
        if (!hdr_sent) begin
            hdr_len = 16'(18 * int'(limit) + 2);
            framed_q.push_back('{hdr_len[15:8], 1'b0});
            framed_q.push_back('{hdr_len[7:0], 1'b0});
            framed_q.push_back('{8'h00, 1'b0});
            framed_q.push_back('{8'h00, 1'b0});
            hdr_sent = 1'b1;
        end
        framed_q.push_back('{b, 1'b0});
        crc_acc = crc16_step(crc_acc, b);
        pack_pos = pack_pos + 4'd1;
        if (pack_pos == 4'd0) begin
            crc_out = crc_acc ^ C_CRC_INV;
            done = packs_out + 12'd1;
            fin = (done >= limit);
            framed_q.push_back('{crc_out[15:8], 1'b0});
            framed_q.push_back('{crc_out[7:0], fin});
            crc_acc = '0;
            if (fin) begin
                packs_out = '0;
                hdr_sent = 1'b0;
            end else begin
                packs_out = done;
            end
        end
    endtask

    task automatic check_output(input logic [7:0] data, input logic last);
        t_framed_byte want;
        if (framed_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b", data, last));
            return;
        end
        want = framed_q.pop_front();
        if (data !== want.data) begin
            report_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
        end
        if (last !== want.last) begin
            report_mismatch($sformatf("last %0b, want %0b (byte %02h)", last, want.last, data));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_output(m_axis_tdata, m_axis_tlast);
        end
    end

    // receiver: random stall pattern, long hold on request
    initial begin : rx_driver
        int stall_left;
        int run_left;
        int hold_left;
        int hold_seen;
        stall_left = 0;
        run_left = 0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_free) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_axis_tready <= 1'b1;
            end else begin
                run_left = $urandom_range(0, 12);
                stall_left = $urandom_range(1, 5);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!tx_free) begin
            if (tx_burst_left == 0) begin
                tx_burst_left = $urandom_range(1, 20);
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            tx_burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_frame(b);
        @(negedge i_clk);
    endtask

    task automatic send_packs(input int packs);
        repeat (packs * BYTES_PER_PACK) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (framed_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // write, then read pack_count back
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_PACK_COUNT) shadow_pack_count = value[11:0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_PACK_COUNT;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== 32'(shadow_pack_count)) begin
            report_mismatch($sformatf("pack_count read %08h, want %03h",
                                      prdata, shadow_pack_count));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_default();
        logic [7:0] pattern [BYTES_PER_PACK];
        pattern = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA,
                    8'h00, 8'h00, 8'hFF, 8'hFF, 8'h10, 8'h21, 8'hC3, 8'h3C};
        tx_free = 1'b1;
        rx_free = 1'b1;
        foreach (pattern[i]) send_byte(pattern[i]);
        wait_drained();
    endtask

    task automatic test_zero_count();
        tx_free = 1'b0;
        rx_free = 1'b0;
        reg_write(ADDR_PACK_COUNT, 32'd0);
        send_packs(2);
        wait_drained();
    endtask

    task automatic test_unmapped_index();
        reg_write(ADDR_UNMAPPED, 32'd5);
        send_packs(1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        reg_write(ADDR_PACK_COUNT, 32'd3);
        tx_free = 1'b1;
        rx_free = 1'b0;
        hold_req++;
        send_packs(3);
        wait_drained();
        tx_free = 1'b0;
    endtask

    task automatic test_pack_limit();
        reg_write(ADDR_PACK_COUNT, 32'(C_MAX_PACKS));
        send_packs(2);
        wait_drained();
        // lowered between packs: stream closes at the next pack
        reg_write(ADDR_PACK_COUNT, 32'd2);
        send_packs(1);
        wait_drained();
        // field maximum clamps to the pack limit
        reg_write(ADDR_PACK_COUNT, 32'h0000_0FFF);
        send_packs(1);
        wait_drained();
        reg_write(ADDR_PACK_COUNT, 32'd1);
        send_packs(1);
        wait_drained();
    endtask

    task automatic test_random_streams();
        int sent;
        int packs;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            packs = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            reg_write(ADDR_PACK_COUNT, 32'(packs));
            tx_free = ($urandom_range(0, 4) == 0);
            rx_free = ($urandom_range(0, 4) == 0);
            send_packs(packs);
            sent += packs * BYTES_PER_PACK;
            wait_drained();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_default();
        test_zero_count();
        test_unmapped_index();
        test_backpressure();
        test_pack_limit();
        test_random_streams();
        if (err_count == 0) begin
            $display("cd_text_pack_crc_framer_test: clean");
        end else begin
            $display("cd_text_pack_crc_framer_test: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("cd_text_pack_crc_framer_test: errors");
        $finish;
    end

endmodule
